FILE: design/assert_macros.svh
// Assertion macros shared by the design files.
// With SYNTH defined the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Condition must hold at every clock edge outside reset
`define RDCFS_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
// Antecedent in a cycle implies consequent in the same cycle
`define RDCFS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);
// Antecedent in a cycle implies consequent in the next cycle
`define RDCFS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define RDCFS_ASSERT_ALWAYS(lbl, cond, msg)
`define RDCFS_ASSERT_IMP(lbl, ante, cons, msg)
`define RDCFS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: design/rdcfs_pkg.sv
// ----------------------------------------------------------------------------
// rdcfs_pkg
// Types, code tables and constants for the RTS/DTR command frame sender.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rdcfs_pkg;

   localparam int unsigned MAX_STEPS  = 6;
   localparam int unsigned FRAME_BITS = 40;
   localparam int unsigned WORD_W     = 16;
   localparam int unsigned TICK_W     = 16;
   localparam int unsigned BIT_IDX_W  = 6;
   localparam int unsigned FRAMES_W   = 3;

   localparam logic [7:0] FRAME_HDR0   = 8'hD5;
   localparam logic [7:0] FRAME_HDR1   = 8'hAA;
   localparam logic [7:0] FRAME_FOOTER = 8'hAD;

   localparam logic [1:0] CMD_ON       = 2'd0;
   localparam logic [1:0] CMD_OFF      = 2'd1;
   localparam logic [1:0] CMD_BRIGHTEN = 2'd2;
   localparam logic [1:0] CMD_DIM      = 2'd3;

   localparam logic KIND_TICK    = 1'b0;
   localparam logic KIND_REQUEST = 1'b1;

   // register indexes on the csr port
   localparam logic [1:0] REG_BIT_DELAY = 2'd0;
   localparam logic [1:0] REG_FRAME_GAP = 2'd1;

   localparam logic [TICK_W-1:0] BIT_DELAY_RESET = 16'd5;
   localparam logic [TICK_W-1:0] FRAME_GAP_RESET = 16'd5000;

   // line levels: bit 1 is RTS, bit 0 is DTR
   localparam logic [1:0] LINES_LOW     = 2'b00;
   localparam logic [1:0] LINES_STANDBY = 2'b11;
   localparam logic [1:0] LINES_ONE     = 2'b10;
   localparam logic [1:0] LINES_ZERO    = 2'b01;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_STBY1 = 3'd1,
      PH_STBY2 = 3'd2,
      PH_SIG   = 3'd3,
      PH_SPACE = 3'd4,
      PH_GAP   = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      ST_NONE     = 2'd0,
      ST_ACCEPTED = 2'd1,
      ST_BADSTEPS = 2'd2,
      ST_BUSY     = 2'd3
   } status_type;

   typedef struct packed {
      logic       kind;
      logic [3:0] house;
      logic [3:0] unit;
      logic [1:0] command;
      logic [2:0] steps;
   } req_type;

   typedef struct packed {
      logic       rts_level;
      logic       dtr_level;
      logic       busy_res;
      logic [1:0] status;
   } rsp_type;

   // decoded request, passed from the word builder to the sender
   typedef struct packed {
      logic [WORD_W-1:0]   first_word;
      logic [WORD_W-1:0]   repeat_word;
      logic [FRAMES_W-1:0] frames;
      logic                steps_ok;
   } code_type;

   function automatic logic [WORD_W-1:0] house_code(input logic [3:0] house);
      logic [WORD_W-1:0] code;
      case (house)
         4'd0:    code = 16'h6000;
         4'd1:    code = 16'h7000;
         4'd2:    code = 16'h4000;
         4'd3:    code = 16'h5000;
         4'd4:    code = 16'h8000;
         4'd5:    code = 16'h9000;
         4'd6:    code = 16'hA000;
         4'd7:    code = 16'hB000;
         4'd8:    code = 16'hE000;
         4'd9:    code = 16'hF000;
         4'd10:   code = 16'hC000;
         4'd11:   code = 16'hD000;
         4'd12:   code = 16'h0000;
         4'd13:   code = 16'h1000;
         4'd14:   code = 16'h2000;
         default: code = 16'h3000;
      endcase
      return code;
   endfunction

   function automatic logic [WORD_W-1:0] unit_code(input logic [3:0] unit);
      logic [WORD_W-1:0] code;
      case (unit)
         4'd0:    code = 16'h0000;
         4'd1:    code = 16'h0010;
         4'd2:    code = 16'h0008;
         4'd3:    code = 16'h0018;
         4'd4:    code = 16'h0040;
         4'd5:    code = 16'h0050;
         4'd6:    code = 16'h0048;
         4'd7:    code = 16'h0058;
         4'd8:    code = 16'h0400;
         4'd9:    code = 16'h0410;
         4'd10:   code = 16'h0408;
         4'd11:   code = 16'h0418;
         4'd12:   code = 16'h0440;
         4'd13:   code = 16'h0450;
         4'd14:   code = 16'h0448;
         default: code = 16'h0458;
      endcase
      return code;
   endfunction

   function automatic logic [WORD_W-1:0] cmd_code(input logic [1:0] command);
      logic [WORD_W-1:0] code;
      case (command)
         CMD_ON:       code = 16'h0000;
         CMD_OFF:      code = 16'h0020;
         CMD_BRIGHTEN: code = 16'h0088;
         default:      code = 16'h0098;
      endcase
      return code;
   endfunction

endpackage

FILE: design/rts_dtr_command_frame_sender_top.sv
// ----------------------------------------------------------------------------
// rts_dtr_command_frame_sender_top
// Two-line serial command frame sender with csr port and registered result.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one item per handshake: a time tick (kind 0) or a
//   command request (kind 1). Every item yields exactly one result item on
//   the rsp_ channel with the line levels after it, the busy flag and a
//   status (none, accepted, bad steps, busy).
//   The result of an item is registered and presented in the cycle
//   after it is taken. One item per cycle is sustained; the only limit is
//   the single result register, which is refilled in the cycle it is taken.
//   When the receiver stalls, the held result stays put and req_ready drops
//   until it is taken; no item is lost or reordered.
//   csr_ writes (index 0 bit delay, index 1 frame gap) are always taken;
//   other indexes are ignored.
//   Synchronous reset clears the sender to idle with both lines low and
//   loads bit delay 5 and frame gap 5000; no result is pending after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rts_dtr_command_frame_sender_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  rdcfs_pkg::req_type             req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output rdcfs_pkg::rsp_type             rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [1:0]                     csr_index,
   input  logic [rdcfs_pkg::TICK_W-1:0]   csr_wdata
);

   logic [rdcfs_pkg::TICK_W-1:0] bit_delay_ff, bit_delay_in;
   logic [rdcfs_pkg::TICK_W-1:0] frame_gap_ff, frame_gap_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rdcfs_pkg::rsp_type           rsp_ff, rsp_in;
   rdcfs_pkg::code_type          code;
   rdcfs_pkg::rsp_type           result;
   logic                         item_en;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign item_en   = req_valid && req_ready;

   rdcfs_word u_word (
      .req  (req_data),
      .code (code)
   );

   rdcfs_sender u_sender (
      .clock     (clock),
      .reset     (reset),
      .item_en   (item_en),
      .req       (req_data),
      .code      (code),
      .bit_delay (bit_delay_ff),
      .frame_gap (frame_gap_ff),
      .result    (result)
   );

   always_comb begin
      bit_delay_in = bit_delay_ff;
      frame_gap_in = frame_gap_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            rdcfs_pkg::REG_BIT_DELAY: bit_delay_in = csr_wdata;
            rdcfs_pkg::REG_FRAME_GAP: frame_gap_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (item_en) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_delay_ff <= rdcfs_pkg::BIT_DELAY_RESET;
         frame_gap_ff <= rdcfs_pkg::FRAME_GAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         bit_delay_ff <= bit_delay_in;
         frame_gap_ff <= frame_gap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // an accepted request always leaves the lines in standby and the sender busy
   `RDCFS_ASSERT_IMP(a_accept_standby, rsp_valid_ff && (rsp_ff.status == rdcfs_pkg::ST_ACCEPTED), rsp_ff.busy_res && rsp_ff.rts_level && rsp_ff.dtr_level, "accepted request not in standby")
   // a busy rejection only happens while frames are in flight
   `RDCFS_ASSERT_IMP(a_busy_reject, rsp_valid_ff && (rsp_ff.status == rdcfs_pkg::ST_BUSY), rsp_ff.busy_res, "busy rejection while idle")
   // when idle the two lines are never split
   `RDCFS_ASSERT_IMP(a_idle_lines, rsp_valid_ff && !rsp_ff.busy_res, rsp_ff.rts_level == rsp_ff.dtr_level, "split lines while idle")
   // every taken item gives a result in the next cycle
   `RDCFS_ASSERT_NEXT(a_result_follows, item_en, rsp_valid_ff, "item without result")

endmodule

FILE: design/rdcfs_word.sv
// ----------------------------------------------------------------------------
// rdcfs_word
// Builds the command words and frame count for a request from the code tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rdcfs_word (
   input  rdcfs_pkg::req_type  req,
   output rdcfs_pkg::code_type code
);

   logic [rdcfs_pkg::WORD_W-1:0] house_bits;
   logic [rdcfs_pkg::WORD_W-1:0] unit_bits;
   logic                         is_dimmer;

   assign house_bits = rdcfs_pkg::house_code(req.house);
   assign unit_bits  = rdcfs_pkg::unit_code(req.unit);
   assign is_dimmer  = (req.command == rdcfs_pkg::CMD_BRIGHTEN) ||
                       (req.command == rdcfs_pkg::CMD_DIM);

   always_comb begin
      code.first_word = house_bits | unit_bits | rdcfs_pkg::cmd_code(rdcfs_pkg::CMD_ON);
      if (is_dimmer) begin
         // brighten and dim carry no unit bits; an ON frame addresses the unit first
         code.repeat_word = house_bits | rdcfs_pkg::cmd_code(req.command);
         code.frames      = req.steps;
         code.steps_ok    = (req.steps != 3'd0) &&
                            (req.steps <= 3'(rdcfs_pkg::MAX_STEPS));
      end else begin
         code.repeat_word = house_bits | unit_bits | rdcfs_pkg::cmd_code(req.command);
         code.first_word  = code.repeat_word;
         code.frames      = '0;
         code.steps_ok    = 1'b1;
      end
   end

endmodule

FILE: design/rdcfs_sender.sv
// ----------------------------------------------------------------------------
// rdcfs_sender
// Frame sequencer: phase, tick counter, frame shift register and line levels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rdcfs_sender (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 item_en,
   input  rdcfs_pkg::req_type                   req,
   input  rdcfs_pkg::code_type                  code,
   input  logic [rdcfs_pkg::TICK_W-1:0]         bit_delay,
   input  logic [rdcfs_pkg::TICK_W-1:0]         frame_gap,
   output rdcfs_pkg::rsp_type                   result
);

   rdcfs_pkg::phase_type                 phase_ff, phase_in;
   logic [1:0]                           lines_ff, lines_in;
   logic [rdcfs_pkg::TICK_W-1:0]         tick_ff, tick_in;
   logic [rdcfs_pkg::BIT_IDX_W-1:0]      bit_ff, bit_in;
   logic [rdcfs_pkg::FRAME_BITS-1:0]     shift_ff, shift_in;
   logic [rdcfs_pkg::FRAMES_W-1:0]       frames_ff, frames_in;
   logic [rdcfs_pkg::WORD_W-1:0]         repeat_ff, repeat_in;

   rdcfs_pkg::status_type                status;
   logic [rdcfs_pkg::TICK_W-1:0]         dur;
   logic [rdcfs_pkg::TICK_W-1:0]         tick_inc;
   logic [rdcfs_pkg::BIT_IDX_W-1:0]      bit_inc;
   logic                                 load_en;
   logic [rdcfs_pkg::WORD_W-1:0]         load_word;
   logic                                 end_frame;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= rdcfs_pkg::PH_IDLE;
         lines_ff  <= rdcfs_pkg::LINES_LOW;
         tick_ff   <= '0;
         bit_ff    <= '0;
         shift_ff  <= '0;
         frames_ff <= '0;
         repeat_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         lines_ff  <= lines_in;
         tick_ff   <= tick_in;
         bit_ff    <= bit_in;
         shift_ff  <= shift_in;
         frames_ff <= frames_in;
         repeat_ff <= repeat_in;
      end
   end

   always_comb begin
      dur = (phase_ff == rdcfs_pkg::PH_GAP) ? frame_gap : bit_delay;
      if (dur == '0) begin
         dur = 16'd1;
      end
   end

   assign tick_inc = tick_ff + 16'd1;
   assign bit_inc  = bit_ff + 6'd1;

   always_comb begin
      phase_in  = phase_ff;
      lines_in  = lines_ff;
      tick_in   = tick_ff;
      bit_in    = bit_ff;
      shift_in  = shift_ff;
      frames_in = frames_ff;
      repeat_in = repeat_ff;
      status    = rdcfs_pkg::ST_NONE;
      load_en   = 1'b0;
      load_word = code.first_word;
      end_frame = 1'b0;

      if (item_en) begin
         if (req.kind == rdcfs_pkg::KIND_REQUEST) begin
            // busy check comes before the steps check
            if (phase_ff != rdcfs_pkg::PH_IDLE) begin
               status = rdcfs_pkg::ST_BUSY;
            end else if (!code.steps_ok) begin
               status = rdcfs_pkg::ST_BADSTEPS;
            end else begin
               status    = rdcfs_pkg::ST_ACCEPTED;
               repeat_in = code.repeat_word;
               frames_in = code.frames;
               load_en   = 1'b1;
               load_word = code.first_word;
            end
         end else if (phase_ff != rdcfs_pkg::PH_IDLE) begin
            tick_in = tick_inc;
            if (tick_inc >= dur) begin
               tick_in = '0;
               case (phase_ff)
                  rdcfs_pkg::PH_STBY1: begin
                     phase_in = rdcfs_pkg::PH_STBY2;
                  end
                  rdcfs_pkg::PH_STBY2: begin
                     phase_in = rdcfs_pkg::PH_SIG;
                     lines_in = shift_ff[rdcfs_pkg::FRAME_BITS-1] ?
                                rdcfs_pkg::LINES_ONE : rdcfs_pkg::LINES_ZERO;
                  end
                  rdcfs_pkg::PH_SIG: begin
                     phase_in = rdcfs_pkg::PH_SPACE;
                     lines_in = rdcfs_pkg::LINES_STANDBY;
                  end
                  rdcfs_pkg::PH_SPACE: begin
                     shift_in = {shift_ff[rdcfs_pkg::FRAME_BITS-2:0], 1'b0};
                     bit_in   = bit_inc;
                     if (bit_inc >= 6'(rdcfs_pkg::FRAME_BITS)) begin
                        if (frame_gap == '0) begin
                           end_frame = 1'b1;
                        end else begin
                           phase_in = rdcfs_pkg::PH_GAP;
                           lines_in = rdcfs_pkg::LINES_STANDBY;
                        end
                     end else begin
                        phase_in = rdcfs_pkg::PH_SIG;
                        lines_in = shift_ff[rdcfs_pkg::FRAME_BITS-2] ?
                                   rdcfs_pkg::LINES_ONE : rdcfs_pkg::LINES_ZERO;
                     end
                  end
                  rdcfs_pkg::PH_GAP: begin
                     end_frame = 1'b1;
                  end
                  default: begin
                     phase_in = rdcfs_pkg::PH_IDLE;
                  end
               endcase
            end
         end
      end

      // next repeat frame, or back to idle in standby
      if (end_frame) begin
         if (frames_ff != '0) begin
            frames_in = frames_ff - 3'd1;
            load_en   = 1'b1;
            load_word = repeat_ff;
         end else begin
            phase_in = rdcfs_pkg::PH_IDLE;
            lines_in = rdcfs_pkg::LINES_STANDBY;
         end
      end

      if (load_en) begin
         shift_in = {rdcfs_pkg::FRAME_HDR0, rdcfs_pkg::FRAME_HDR1, load_word,
                     rdcfs_pkg::FRAME_FOOTER};
         bit_in   = '0;
         tick_in  = '0;
         phase_in = rdcfs_pkg::PH_STBY1;
         lines_in = rdcfs_pkg::LINES_STANDBY;
      end
   end

   assign result.rts_level = lines_in[1];
   assign result.dtr_level = lines_in[0];
   assign result.busy_res  = (phase_in != rdcfs_pkg::PH_IDLE);
   assign result.status    = status;

endmodule
